@@ rtl/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// Type codes and the floating point helper functions used by the pixel
// format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam logic [3:0] T_S8      = 4'd0;
    localparam logic [3:0] T_U8      = 4'd1;
    localparam logic [3:0] T_S16     = 4'd2;
    localparam logic [3:0] T_U16     = 4'd3;
    localparam logic [3:0] T_S16SW   = 4'd4;
    localparam logic [3:0] T_S32     = 4'd5;
    localparam logic [3:0] T_U32     = 4'd6;
    localparam logic [3:0] T_SINGLE  = 4'd7;
    localparam logic [3:0] T_COMPLEX = 4'd8;
    localparam logic [3:0] T_DOUBLE  = 4'd9;
    localparam logic [3:0] T_RGB     = 4'd10;
    localparam logic [3:0] T_ARGB    = 4'd11;

    localparam logic [0:0] REG_SOURCE = 1'b0;
    localparam logic [0:0] REG_TARGET = 1'b1;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    // magnitudes at or above this overflow a single
    localparam logic [62:0] NARROW_OVF = 63'h47EF_FFFF_F000_0000;

    // single to double, exact; signaling NaNs come out quiet
    function automatic logic [63:0] f2d(input logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [22:0] nm;
        logic [4:0]  lz;
        logic [63:0] r;
        e  = f[30:23];
        m  = f[22:0];
        lz = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) lz = 5'(22 - i);
        end
        nm = m << (lz + 5'd1);
        if (e == 8'hFF) begin
            r = {f[31], 11'h7FF, m[22] | (m != 23'd0), m[21:0], 29'd0};
        end else if (e == 8'd0) begin
            if (m == 23'd0) r = {f[31], 63'd0};
            else r = {f[31], 11'(11'd896 - 11'(lz)), nm, 29'd0};
        end else begin
            r = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
        end
        return r;
    endfunction

    // double to signed 32 bits: nearest even, saturate, NaN to minimum
    function automatic logic [31:0] round_sat(input logic [63:0] d);
        logic [10:0] e;
        logic [5:0]  sh;
        logic [63:0] sig;
        logic [63:0] ip;
        logic        g;
        logic        st;
        logic [31:0] mag;
        logic [31:0] r;
        e   = d[62:52];
        sh  = 6'(11'd1075 - e);
        sig = {11'd0, 1'b1, d[51:0]};
        ip  = sig >> sh;
        g   = sig[sh - 6'd1];
        st  = (sig & ((64'd1 << (sh - 6'd1)) - 64'd1)) != 64'd0;
        mag = ip[31:0] + {31'd0, g & (st | ip[0])};
        if (e == 11'h7FF && d[51:0] != 52'd0) r = INT_MIN;
        else if (e >= 11'd1054) r = d[63] ? INT_MIN : INT_MAX;
        else if (e < 11'd1022) r = 32'd0;
        else if (!d[63]) r = mag[31] ? INT_MAX : mag;
        else r = 32'd0 - mag;
        return r;
    endfunction

    // double to single, nearest even, subnormal results included
    function automatic logic [31:0] narrow(input logic [63:0] d);
        logic [10:0] e;
        logic        nrm;
        logic [10:0] rr;
        logic [5:0]  sh;
        logic [63:0] sig;
        logic [63:0] ip;
        logic        g;
        logic        st;
        logic [7:0]  ex;
        logic [30:0] b;
        logic [31:0] r;
        e   = d[62:52];
        nrm = e >= 11'd897;
        rr  = nrm ? 11'd29 : 11'(11'd926 - e);
        sh  = rr[5:0];
        sig = {11'd0, 1'b1, d[51:0]};
        ip  = sig >> sh;
        g   = sig[sh - 6'd1];
        st  = (sig & ((64'd1 << (sh - 6'd1)) - 64'd1)) != 64'd0;
        ex  = nrm ? 8'(e - 11'd896) : 8'd0;
        b   = {ex, ip[22:0]} + {30'd0, g & (st | ip[0])};
        if (e == 11'h7FF && d[51:0] != 52'd0)
            r = {d[63], 31'h7FC0_0000 | {9'd0, d[50:29]}};
        else if (d[62:0] >= NARROW_OVF) r = {d[63], 31'h7F80_0000};
        else if (e == 11'd0 || (!nrm && rr > 11'd54)) r = {d[63], 31'd0};
        else r = {d[63], b};
        return r;
    endfunction

endpackage

@@ rtl/pixel_format_converter.sv @@
// ----------------------------------------------------------------------------
// pixel_format_converter
// Converts one pixel word between integer, float, complex, double and
// packed color types chosen by two configuration registers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = pixel_in
//  m_*       out  m_tvalid/m_tready  m_tdata = pixel_out, m_tuser = bad_pair
//  cfg_*     in   cfg_wr_en          cfg_addr 0 source, 1 target
//
//  One beat per clock sustained while m_tready stays high; an accepted beat
//  passes input register, conversion logic, result register, in that order.
//  The longest path is single to double widening, an alignment shift, a
//  rounding add and a negate. Reset clears both valid flags and the type
//  registers to zero. A stall on m_tready holds the result and backs up into
//  the input register; s_tready drops only when both registers are full and
//  m_tready is low.
module pixel_format_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] pixel_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] pixel_out
    output logic [0:0]  m_tuser,   // [0] bad_pair
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    logic [3:0]  src_reg, tgt_reg;
    logic        in_vld_reg, out_vld_reg;
    logic [63:0] in_data_reg, out_data_reg;
    logic        out_bad_reg;
    logic        advance;

    logic [63:0] x;
    logic        int_src, flt_src;
    logic [32:0] iv;
    logic [63:0] dbits;
    logic [31:0] v32;
    logic [32:0] mag33;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic [31:0] nrm;
    logic [30:0] sgl_b;
    logic [31:0] i2s;
    logic [63:0] i2d;
    logic [63:0] res_next;
    logic        bad_next;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

    assign x       = in_data_reg;
    assign int_src = (src_reg <= pfc_pkg::T_S32) && (src_reg != pfc_pkg::T_S16SW);
    assign flt_src = (src_reg >= pfc_pkg::T_SINGLE) && (src_reg <= pfc_pkg::T_DOUBLE);

    always_comb begin
        unique case (src_reg)
            pfc_pkg::T_S8:  iv = {{25{x[7]}}, x[7:0]};
            pfc_pkg::T_U8:  iv = {25'd0, x[7:0]};
            pfc_pkg::T_S16: iv = {{17{x[15]}}, x[15:0]};
            pfc_pkg::T_U16: iv = {17'd0, x[15:0]};
            pfc_pkg::T_S32: iv = {x[31], x[31:0]};
            default:        iv = {1'b0, x[31:0]};
        endcase
    end

    assign dbits = (src_reg == pfc_pkg::T_DOUBLE) ? x : pfc_pkg::f2d(x[31:0]);
    assign v32   = int_src ? iv[31:0] : pfc_pkg::round_sat(dbits);

    // integer to float: normalize the magnitude, then round to 24 bits
    assign mag33 = iv[32] ? 33'd0 - iv : iv;
    assign mag   = mag33[31:0];
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) lz = 5'(31 - i);
        end
    end
    assign nrm   = mag << lz;
    assign sgl_b = {8'(8'd158 - {3'd0, lz}), nrm[30:8]}
                   + {30'd0, nrm[7] & ((nrm[6:0] != 7'd0) | nrm[8])};
    assign i2s   = (mag == 32'd0) ? 32'd0 : {iv[32], sgl_b};
    assign i2d   = (mag == 32'd0) ? 64'd0
                   : {iv[32], 11'(11'd1054 - {6'd0, lz}), nrm[30:0], 21'd0};

    always_comb begin
        res_next = 64'd0;
        bad_next = 1'b0;
        unique case (tgt_reg)
            pfc_pkg::T_S8, pfc_pkg::T_U8, pfc_pkg::T_S16, pfc_pkg::T_U16,
            pfc_pkg::T_S32: begin
                if (int_src || flt_src) begin
                    if ((tgt_reg == pfc_pkg::T_U8 || tgt_reg == pfc_pkg::T_U16)
                        && v32[31])
                        res_next = 64'd0;
                    else if (tgt_reg <= pfc_pkg::T_U8)
                        res_next = {56'd0, v32[7:0]};
                    else if (tgt_reg <= pfc_pkg::T_U16)
                        res_next = {48'd0, v32[15:0]};
                    else
                        res_next = {32'd0, v32};
                end else if (src_reg == pfc_pkg::T_S16SW && tgt_reg == pfc_pkg::T_S16) begin
                    res_next = {48'd0, x[7:0], x[15:8]};
                end else if (src_reg == pfc_pkg::T_RGB && tgt_reg == pfc_pkg::T_S32) begin
                    res_next = {32'd0, x[23:0], 8'hFF};
                end else if (src_reg == pfc_pkg::T_ARGB && tgt_reg == pfc_pkg::T_S32) begin
                    res_next = {32'd0, x[31:0]};
                end else begin
                    bad_next = 1'b1;
                end
            end
            pfc_pkg::T_SINGLE, pfc_pkg::T_COMPLEX: begin
                if (int_src) res_next = {32'd0, i2s};
                else if (src_reg == pfc_pkg::T_SINGLE) res_next = {32'd0, x[31:0]};
                else if (src_reg == pfc_pkg::T_COMPLEX)
                    res_next = (tgt_reg == pfc_pkg::T_COMPLEX) ? x : {32'd0, x[31:0]};
                else if (src_reg == pfc_pkg::T_DOUBLE)
                    res_next = {32'd0, pfc_pkg::narrow(x)};
                else bad_next = 1'b1;
            end
            pfc_pkg::T_DOUBLE: begin
                if (int_src || src_reg == pfc_pkg::T_U32) res_next = i2d;
                else if (flt_src) res_next = dbits;
                else bad_next = 1'b1;
            end
            default: bad_next = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg     <= pfc_pkg::T_S8;
            tgt_reg     <= pfc_pkg::T_S8;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pfc_pkg::REG_SOURCE: src_reg <= cfg_wdata;
                    pfc_pkg::REG_TARGET: tgt_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tready) in_vld_reg <= s_tvalid;
            if (advance)  out_vld_reg <= in_vld_reg;
        end
        // payload: hold on stall
        if (s_tready && s_tvalid) in_data_reg <= s_tdata;
        if (advance && in_vld_reg) begin
            out_data_reg <= res_next;
            out_bad_reg  <= bad_next;
        end
    end

    // a flagged pair never carries data
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
        else $error("bad pair with nonzero data");

    // a beat in the input register moves on when the output frees
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && advance |=> m_tvalid)
        else $error("beat lost between stages");

    // an empty output never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule
